>>> rtl/imu_frame_parser_unit_defines.svh
// Assertion macros used by the IMU frame parser core.
`ifndef IMU_FRAME_PARSER_UNIT_DEFINES_SVH
`define IMU_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define IFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IFP_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define IFP_ASSERT(name, prop, msg)
`define IFP_ASSERT_NEXT(name, cond, prop, msg)
`endif

`endif

>>> rtl/imu_fp_pkg.sv
// Types and constants of the IMU frame parser.
`default_nettype none

package imu_fp_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 160;
  localparam int RES_W      = 153;

  localparam logic [7:0] HDR_BYTE  = 8'h5A;
  localparam logic [7:0] TYPE_GYRO = 8'hAA;
  localparam logic [7:0] TYPE_YAW  = 8'hBB;

  localparam logic [2:0] FRAME_LAST = 3'd4;

  localparam logic signed [11:0] GYRO_SCALE = 12'sd2000;
  localparam logic signed [8:0]  YAW_SCALE  = 9'sd180;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_BUSY  = 3'd2,
    ST_CRC   = 3'd3,
    ST_TYPE  = 3'd4
  } status_code_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  rx_byte;
    logic        action;
  } item_t;

  typedef struct packed {
    logic               fresh;
    logic [31:0]        last_update_ms;
    logic [31:0]        bad_frames;
    logic [31:0]        good_frames;
    logic               yaw_ok;
    logic signed [23:0] yaw_angle;
    logic               gyro_ok;
    logic signed [26:0] gyro_rate;
    status_code_t       status;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/imu_fp_in_reg.sv
// Input register stage holding one request until the core takes it.
`default_nettype none

module imu_fp_in_reg
  import imu_fp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic                 in_user,
  input  logic                 advance,
  output logic                 item_valid,
  output item_t                item
);

  assign in_ready = !rst && (!item_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.action  <= in_user;
      item.rx_byte <= in_data[7:0];
      item.now_ms  <= in_data[39:8];
    end
  end

endmodule

`default_nettype wire

>>> rtl/imu_fp_core.sv
// Frame decode, sample state and result register of the IMU frame parser.
`default_nettype none

`include "imu_frame_parser_unit_defines.svh"

module imu_fp_core
  import imu_fp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    advance,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic [2:0]         idx, idx_next;
  logic [3:0][7:0]    fb, fb_next;
  logic signed [26:0] gyro, gyro_next;
  logic               gyro_seen, gyro_seen_next;
  logic signed [23:0] yaw, yaw_next;
  logic               yaw_seen, yaw_seen_next;
  logic [31:0]        ok_count, ok_count_next;
  logic [31:0]        err_count, err_count_next;
  logic [31:0]        stamp, stamp_next;
  logic               new_flag, new_flag_next;

  logic [7:0]         sum;
  logic signed [15:0] raw;
  logic signed [26:0] gyro_prod;
  logic signed [23:0] yaw_prod;
  status_code_t       status;
  logic               fresh_out;

  assign advance   = item_valid && (!res_valid || res_ready);
  assign sum       = fb[0] + fb[1] + fb[2] + fb[3];
  assign raw       = $signed({fb[3], fb[2]});
  assign gyro_prod = 27'(raw) * 27'(GYRO_SCALE);
  assign yaw_prod  = 24'(raw) * 24'(YAW_SCALE);

  always_comb begin
    idx_next       = idx;
    fb_next        = fb;
    gyro_next      = gyro;
    gyro_seen_next = gyro_seen;
    yaw_next       = yaw;
    yaw_seen_next  = yaw_seen;
    ok_count_next  = ok_count;
    err_count_next = err_count;
    stamp_next     = stamp;
    new_flag_next  = new_flag;
    status         = ST_EMPTY;
    fresh_out      = new_flag;
    if (item.action) begin
      status        = (gyro_seen || yaw_seen) ? ST_OK : ST_EMPTY;
      new_flag_next = 1'b0;
    end else begin
      if (idx == 3'd0) begin
        if (item.rx_byte == HDR_BYTE) begin
          fb_next[0] = item.rx_byte;
          idx_next   = 3'd1;
          status     = ST_BUSY;
        end
      end else if (idx < FRAME_LAST) begin
        fb_next[idx[1:0]] = item.rx_byte;
        idx_next          = idx + 3'd1;
        status            = ST_BUSY;
      end else begin
        idx_next = 3'd0;
        if (sum != item.rx_byte) begin
          err_count_next = err_count + 32'd1;
          status         = ST_CRC;
          if (item.rx_byte == HDR_BYTE) begin
            fb_next[0] = HDR_BYTE;
            idx_next   = 3'd1;
          end
        end else if (fb[1] == TYPE_GYRO || fb[1] == TYPE_YAW) begin
          if (fb[1] == TYPE_GYRO) begin
            gyro_next      = gyro_prod;
            gyro_seen_next = 1'b1;
          end else begin
            yaw_next      = yaw_prod;
            yaw_seen_next = 1'b1;
          end
          ok_count_next = ok_count + 32'd1;
          stamp_next    = item.now_ms;
          new_flag_next = 1'b1;
          status        = ST_OK;
        end else begin
          err_count_next = err_count + 32'd1;
          status         = ST_TYPE;
        end
      end
      fresh_out = new_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      fb        <= '0;
      gyro      <= '0;
      gyro_seen <= 1'b0;
      yaw       <= '0;
      yaw_seen  <= 1'b0;
      ok_count  <= '0;
      err_count <= '0;
      stamp     <= '0;
      new_flag  <= 1'b0;
    end else if (advance) begin
      idx       <= idx_next;
      fb        <= fb_next;
      gyro      <= gyro_next;
      gyro_seen <= gyro_seen_next;
      yaw       <= yaw_next;
      yaw_seen  <= yaw_seen_next;
      ok_count  <= ok_count_next;
      err_count <= err_count_next;
      stamp     <= stamp_next;
      new_flag  <= new_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.status         <= status;
      res.gyro_rate      <= gyro_next;
      res.gyro_ok        <= gyro_seen_next;
      res.yaw_angle      <= yaw_next;
      res.yaw_ok         <= yaw_seen_next;
      res.good_frames    <= ok_count_next;
      res.bad_frames     <= err_count_next;
      res.last_update_ms <= stamp_next;
      res.fresh          <= fresh_out;
    end
  end

  `IFP_ASSERT(a_idx_range, idx <= FRAME_LAST, "frame byte index out of range")
  `IFP_ASSERT_NEXT(a_hold_state, !advance,
                   $stable(ok_count) && $stable(err_count) && $stable(idx),
                   "state moved without a request")
  `IFP_ASSERT_NEXT(a_read_clears, advance && item.action,
                   !new_flag && res.fresh == $past(new_flag), "read did not clear new-data")
  `IFP_ASSERT_NEXT(a_ok_count, advance && status == ST_OK && !item.action,
                   ok_count == $past(ok_count) + 32'd1 && new_flag,
                   "accepted frame not counted")
  `IFP_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res),
                   "stalled result changed")

endmodule

`default_nettype wire

>>> rtl/imu_frame_parser_unit.sv
// A request's result reaches m_tdata through the input register and then the result register.
// Throughput: one request per cycle while m_tready takes results; the frame state updates in one pass per request.
// The input stage accepts while its register is empty or the core advances, also while a finished result waits.
// Reset (rst, synchronous, active high) clears the frame index, samples, flags and counters.
// After reset the block accepts requests as soon as rst is low.
`default_nettype none

module imu_frame_parser_unit
  import imu_fp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // rx_byte[7:0], now_ms[39:8]
  input  logic                  s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status, gyro_rate, gyro_ok, yaw_angle, yaw_ok,
                                           // good_frames, bad_frames, last_update_ms, fresh
);

  logic    advance;
  logic    item_valid;
  item_t   item;
  result_t res;

  imu_fp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_user    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  imu_fp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {(OUT_DATA_W - RES_W)'(0), res};

endmodule

`default_nettype wire

>>> verif/imu_frame_parser_unit_test.sv
// Self-checking testbench for the IMU frame parser: directed table, random frames, stream stalls.
module imu_frame_parser_unit_test;
  import imu_fp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       action;
    logic [7:0] rx_byte;
    logic [31:0] now_ms;
    logic       typed;
    status_code_t status;
  } uart_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // rx_byte, now_ms
  logic                  s_tuser = 1'b0; // action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // status, gyro_rate, gyro_ok, yaw_angle, yaw_ok,
                                         // good_frames, bad_frames, last_update_ms, fresh

  imu_frame_parser_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [2:0]         frame_pos = '0;
  logic [7:0]         frame_buf [4] = '{default: '0};
  logic signed [26:0] gyro_val = '0;
  logic signed [23:0] yaw_val = '0;
  logic               gyro_have = 1'b0;
  logic               yaw_have = 1'b0;
  logic               new_data = 1'b0;
  logic [31:0]        good_cnt = '0;
  logic [31:0]        bad_cnt = '0;
  logic [31:0]        stamp = '0;

  uart_req_t   byte_req_q [$];
  result_t     sample_q [$];
  uart_req_t   in_flight;
  result_t     expected;
  result_t     got;
  result_t     want;
  int unsigned taken = 0;
  int unsigned offered = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  function automatic result_t next_sample(uart_req_t r);
    result_t            res;
    status_code_t       st;
    logic               fresh_out;
    logic [7:0]         csum;
    logic signed [15:0] raw;
    if (r.action) begin
      fresh_out = new_data;
      new_data = 1'b0;
      st = (gyro_have || yaw_have) ? ST_OK : ST_EMPTY;
    end else begin
      st = ST_BUSY;
      if (frame_pos == 3'd0) begin
        if (r.rx_byte != HDR_BYTE) begin
          st = ST_EMPTY;
        end else begin
          frame_buf[0] = r.rx_byte;
          frame_pos = 3'd1;
        end
      end else if (frame_pos < FRAME_LAST) begin
        frame_buf[frame_pos[1:0]] = r.rx_byte;
        frame_pos = frame_pos + 3'd1;
      end else begin
        frame_pos = 3'd0;
        csum = frame_buf[0] + frame_buf[1] + frame_buf[2] + frame_buf[3];
        raw = {frame_buf[3], frame_buf[2]};
        if (csum != r.rx_byte) begin
          bad_cnt++;
          st = ST_CRC;
          if (r.rx_byte == HDR_BYTE) begin
            frame_buf[0] = HDR_BYTE;
            frame_pos = 3'd1;
          end
        end else if (frame_buf[1] == TYPE_GYRO) begin
          gyro_val = raw * GYRO_SCALE;
          gyro_have = 1'b1;
          st = ST_OK;
        end else if (frame_buf[1] == TYPE_YAW) begin
          yaw_val = raw * YAW_SCALE;
          yaw_have = 1'b1;
          st = ST_OK;
        end else begin
          bad_cnt++;
          st = ST_TYPE;
        end
        if (st == ST_OK) begin
          good_cnt++;
          stamp = r.now_ms;
          new_data = 1'b1;
        end
      end
      fresh_out = new_data;
    end
    res.status = st;
    res.gyro_rate = gyro_val;
    res.gyro_ok = gyro_have;
    res.yaw_angle = yaw_val;
    res.yaw_ok = yaw_have;
    res.good_frames = good_cnt;
    res.bad_frames = bad_cnt;
    res.last_update_ms = stamp;
    res.fresh = fresh_out;
    return res;
  endfunction

  function automatic bit calm();
    return taken >= 250 && taken < 400;
  endfunction

  function automatic void queue_req(logic act, logic [7:0] b);
    byte_req_q.push_back('{act, b, $urandom(), 1'b0, ST_OK});
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected = next_sample(in_flight);
        if (in_flight.typed) begin
          expected.status = in_flight.status;
        end
        sample_q.push_back(expected);
        taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_req_q.size() != 0 && (calm() || $urandom_range(99) >= 38)) begin
          in_flight = byte_req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= in_flight.action;
          s_tdata <= {in_flight.now_ms, in_flight.rx_byte};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= (hold_left == 0) && (calm() || $urandom_range(99) >= 38);
    end
  end

  // hold off the result side long enough to back up the input
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && taken >= 550) begin
        hold_left <= 80;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RES_W-1:0]);
      if (sample_q.size() == 0) begin
        flag_mismatch("result with no request pending");
      end else begin
        want = sample_q.pop_front();
        if (got.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.gyro_rate !== want.gyro_rate)
          flag_mismatch($sformatf("gyro_rate %0d, want %0d", got.gyro_rate, want.gyro_rate));
        if (got.gyro_ok !== want.gyro_ok)
          flag_mismatch($sformatf("gyro_ok %0b, want %0b", got.gyro_ok, want.gyro_ok));
        if (got.yaw_angle !== want.yaw_angle)
          flag_mismatch($sformatf("yaw_angle %0d, want %0d", got.yaw_angle, want.yaw_angle));
        if (got.yaw_ok !== want.yaw_ok)
          flag_mismatch($sformatf("yaw_ok %0b, want %0b", got.yaw_ok, want.yaw_ok));
        if (got.good_frames !== want.good_frames)
          flag_mismatch($sformatf("good_frames %0d, want %0d", got.good_frames,
                                  want.good_frames));
        if (got.bad_frames !== want.bad_frames)
          flag_mismatch($sformatf("bad_frames %0d, want %0d", got.bad_frames, want.bad_frames));
        if (got.last_update_ms !== want.last_update_ms)
          flag_mismatch($sformatf("last_update_ms %0h, want %0h", got.last_update_ms,
                                  want.last_update_ms));
        if (got.fresh !== want.fresh)
          flag_mismatch($sformatf("fresh %0b, want %0b", got.fresh, want.fresh));
      end
      results_seen++;
    end
  end

  initial begin
    uart_req_t          warmup [27];
    int unsigned        counted;
    int unsigned        pick;
    int unsigned        kind;
    logic [7:0]         ftype;
    logic [15:0]        raw;
    logic [7:0]         csum;
    warmup = '{
      '{1'b1, 8'h00, 32'h0000_0000, 1'b1, ST_EMPTY},
      '{1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_EMPTY},
      '{1'b0, 8'h5A, 32'h0000_0001, 1'b0, ST_BUSY},
      '{1'b0, 8'hAA, 32'h0000_0002, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_0003, 1'b0, ST_BUSY},
      '{1'b0, 8'h80, 32'h0000_0004, 1'b0, ST_BUSY},
      '{1'b0, 8'h84, 32'h0000_0000, 1'b1, ST_OK},
      '{1'b0, 8'h5A, 32'h0000_0005, 1'b0, ST_BUSY},
      '{1'b0, 8'hBB, 32'h0000_0006, 1'b0, ST_BUSY},
      '{1'b0, 8'hFF, 32'h0000_0007, 1'b0, ST_BUSY},
      '{1'b0, 8'h7F, 32'h0000_0008, 1'b0, ST_BUSY},
      '{1'b0, 8'h93, 32'hFFFF_FFFF, 1'b1, ST_OK},
      '{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_OK},
      '{1'b0, 8'h5A, 32'h0000_0009, 1'b0, ST_BUSY},
      '{1'b0, 8'hAA, 32'h0000_000A, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_000B, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_000C, 1'b0, ST_BUSY},
      '{1'b0, 8'h5A, 32'h0000_000D, 1'b1, ST_CRC},
      '{1'b0, 8'hBB, 32'h0000_000E, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_000F, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_0010, 1'b0, ST_BUSY},
      '{1'b0, 8'h15, 32'h1234_5678, 1'b0, ST_OK},
      '{1'b0, 8'h5A, 32'h0000_0011, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_0012, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_0013, 1'b0, ST_BUSY},
      '{1'b0, 8'h00, 32'h0000_0015, 1'b0, ST_BUSY},
      '{1'b0, 8'h5A, 32'h0000_0014, 1'b1, ST_TYPE}
    };
    foreach (warmup[i]) byte_req_q.push_back(warmup[i]);
    warmup[0].action = 1'b0;

    counted = 0;
    while (counted < 750) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        queue_req(1'b1, 8'($urandom));
        counted++;
      end else if (pick < 20) begin
        queue_req(1'b0, 8'($urandom));
        counted++;
      end else begin
        kind = $urandom_range(99);
        ftype = (kind < 45) ? TYPE_GYRO : (kind < 90) ? TYPE_YAW : 8'($urandom);
        pick = $urandom_range(9);
        raw = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
        csum = HDR_BYTE + ftype + raw[7:0] + raw[15:8];
        pick = $urandom_range(99);
        if (pick >= 85) begin
          csum = (pick >= 93 && csum != HDR_BYTE) ? HDR_BYTE : csum + 8'($urandom_range(1, 255));
        end
        queue_req(1'b0, HDR_BYTE);
        queue_req(1'b0, ftype);
        if ($urandom_range(19) == 0) begin
          queue_req(1'b1, 8'($urandom));
          counted++;
        end
        queue_req(1'b0, raw[7:0]);
        queue_req(1'b0, raw[15:8]);
        queue_req(1'b0, csum);
        counted += 5;
      end
    end
    offered = byte_req_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (taken < offered) @(posedge clk);
    while (sample_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/imu_fp_pkg.sv
rtl/imu_fp_in_reg.sv
rtl/imu_fp_core.sv
rtl/imu_frame_parser_unit.sv
verif/imu_frame_parser_unit_test.sv
